@@ src/act_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_pkg: shared types and constants of the accelerometer tilt calibrator
// Holds field widths, mode and kind codes, the arctangent table of the CORDIC
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package act_pkg;

	localparam int RAW_WIDTH    = 16;
	localparam int IN_W         = 16;
	localparam int ACC_W        = 17;
	localparam int SUM_W        = 32;
	localparam int CNT_W        = 16;
	localparam int TILT_W       = 16;
	localparam int CW           = 36;
	localparam int ZW           = 27;
	localparam int TAB_W        = 22;
	localparam int SQRT_STEPS   = 32;
	localparam int CORDIC_STEPS = 20;
	localparam int DIV_STEPS    = 33;
	localparam int STEP_W       = 6;

	localparam logic signed [ACC_W-1:0] ONE_G   = 17'sd16384;
	localparam logic signed [ZW-1:0]    Z90     = 27'sd5898240;
	localparam logic signed [ZW-1:0]    Z180    = 27'sd11796480;
	localparam logic [CNT_W-1:0]        SAMPLE_COUNT_RST = 16'd64;

	localparam logic [1:0] MODE_MEASURE = 2'd0;
	localparam logic [1:0] MODE_CAL     = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	localparam logic KIND_TILT = 1'b0;
	localparam logic KIND_CAL  = 1'b1;

	localparam logic REG_SAMPLE_COUNT = 1'b0;

	typedef struct packed {
		logic       load_meas;
		logic       acc;
		logic       clr;
		logic       sq;
		logic       sum;
		logic       sqrt_step;
		logic       cord_init;
		logic       cord_step;
		logic       div_init;
		logic       div_step;
		logic       out_meas;
		logic       out_cal;
		logic [4:0] idx;
	} act_cmd_t;

	typedef struct packed {
		logic zero_vec;
		logic cal_last;
		logic cnt_zero;
	} act_sts_t;

	// Sign extension of the low RAW_WIDTH bits of a raw sample.
	function automatic logic signed [ACC_W-1:0] sext_raw(input logic [IN_W-1:0] v);
		logic [RAW_WIDTH-1:0] t;
		t = v[RAW_WIDTH-1:0];
		return {{(ACC_W-RAW_WIDTH){t[RAW_WIDTH-1]}}, t};
	endfunction

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic [TAB_W-1:0] atan_tab(input logic [4:0] i);
		logic [TAB_W-1:0] r;
		case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ src/accel_tilt_calibrator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_calibrator_unit: accelerometer tilt angles with bias calibration
// Takes raw 3-axis samples, applies a calibrated bias and reports the three
// tilt angles, averages samples into a new bias, or clears the calibration.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid/in_ready) carries a mode and
// one raw sample. A measure request yields one tilt result on the output
// channel (out_valid/out_ready); the next request is taken only once that
// result has entered the output register, so measures do not overlap.
// Each measure runs the 32 steps of the bit-serial square root followed
// by the 20 CORDIC steps, all three axes running in parallel lanes.
// A measure whose corrected vector is zero gives no result.
// The last calibration sample of a run starts the 33-step restoring division,
// then emits a calibration-done result.
// A clear request gives no result.
// Results sit in an output register: a new request is accepted while a
// result waits, and its own result holds in the sequencer until the receiver
// takes the earlier one. sample_count is written through the APB port.
// Reset clears the calibration, the running sums and sets sample_count to 64.
// ----------------------------------------------------------------------------
module accel_tilt_calibrator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic [act_pkg::IN_W-1:0]             raw_x,
	input  logic [act_pkg::IN_W-1:0]             raw_y,
	input  logic [act_pkg::IN_W-1:0]             raw_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 kind,
	output logic signed [act_pkg::ACC_W-1:0]     acc_x,
	output logic signed [act_pkg::ACC_W-1:0]     acc_y,
	output logic signed [act_pkg::ACC_W-1:0]     acc_z,
	output logic [act_pkg::TILT_W-1:0]           tilt_x,
	output logic [act_pkg::TILT_W-1:0]           tilt_y,
	output logic [act_pkg::TILT_W-1:0]           tilt_z,
	output logic                                 cal_valid
);

	logic [act_pkg::CNT_W-1:0] sample_count_q;
	act_pkg::act_cmd_t         cmd;
	act_pkg::act_sts_t         sts;

	// The register file holds one register; it is written in the access phase.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == act_pkg::REG_SAMPLE_COUNT) ?
		{16'b0, sample_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= act_pkg::SAMPLE_COUNT_RST;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == act_pkg::REG_SAMPLE_COUNT)) begin
			sample_count_q <= pwdata[15:0];
		end
	end

	// The sequencer decides what each request does and paces the datapath.
	act_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the bias, the running sums and the three axis lanes.
	act_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_count (sample_count_q),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.raw_z        (raw_z),
		.kind         (kind),
		.acc_x        (acc_x),
		.acc_y        (acc_y),
		.acc_z        (acc_z),
		.tilt_x       (tilt_x),
		.tilt_y       (tilt_y),
		.tilt_z       (tilt_z),
		.cal_valid    (cal_valid)
	);

`ifndef SYNTHESIS
	a_cal_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == act_pkg::KIND_CAL |-> cal_valid)
		else $error("calibration result without valid calibration");

	a_cal_no_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == act_pkg::KIND_CAL |-> tilt_x == '0 && tilt_y == '0 && tilt_z == '0)
		else $error("calibration result carries angles");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == act_pkg::KIND_TILT |->
		tilt_x <= 16'd46080 && tilt_y <= 16'd46080 && tilt_z <= 16'd46080)
		else $error("tilt angle above 180 degrees");

	a_busy_holds_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == act_pkg::MODE_MEASURE && !out_valid |=>
		!out_valid || !in_ready)
		else $error("measure result appeared without sequencing");
`endif

endmodule

@@ src/act_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_dp: datapath of the accelerometer tilt calibrator
// Three lanes (x, y, z) of bias correction, squaring, bit-serial square root,
// CORDIC vectoring and restoring division, plus the calibration state.
// ----------------------------------------------------------------------------
module act_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  act_pkg::act_cmd_t                    cmd,
	output act_pkg::act_sts_t                    sts,
	input  logic [act_pkg::CNT_W-1:0]            sample_count,
	input  logic [act_pkg::IN_W-1:0]             raw_x,
	input  logic [act_pkg::IN_W-1:0]             raw_y,
	input  logic [act_pkg::IN_W-1:0]             raw_z,
	output logic                                 kind,
	output logic signed [act_pkg::ACC_W-1:0]     acc_x,
	output logic signed [act_pkg::ACC_W-1:0]     acc_y,
	output logic signed [act_pkg::ACC_W-1:0]     acc_z,
	output logic [act_pkg::TILT_W-1:0]           tilt_x,
	output logic [act_pkg::TILT_W-1:0]           tilt_y,
	output logic [act_pkg::TILT_W-1:0]           tilt_z,
	output logic                                 cal_valid
);

	logic signed [act_pkg::ACC_W-1:0]   raw_s [3];
	logic signed [act_pkg::ACC_W+1:0]   diff [3];
	logic signed [act_pkg::ACC_W-1:0]   corr [3];
	logic signed [act_pkg::ACC_W-1:0]   bias_q [3];
	logic                               bias_valid_q;
	logic signed [act_pkg::SUM_W-1:0]   sum_q [3];
	logic [act_pkg::CNT_W-1:0]          taken_q;
	logic [act_pkg::CNT_W-1:0]          taken_nx;

	logic signed [act_pkg::ACC_W-1:0]   acc_q [3];
	logic signed [2*act_pkg::ACC_W-1:0] prod [3];
	logic [2*act_pkg::ACC_W-2:0]        sq_q [3];
	logic [2*act_pkg::ACC_W-1:0]        ss [3];
	logic [63:0]                        rad_q [3];
	logic [63:0]                        root_q [3];
	logic [63:0]                        bit_q;
	logic [63:0]                        trial [3];

	logic signed [act_pkg::CW-1:0]      xa [3];
	logic signed [act_pkg::CW-1:0]      yr [3];
	logic signed [act_pkg::CW-1:0]      cx_q [3];
	logic signed [act_pkg::CW-1:0]      cy_q [3];
	logic signed [act_pkg::ZW-1:0]      cz_q [3];
	logic signed [act_pkg::CW-1:0]      xs [3];
	logic signed [act_pkg::CW-1:0]      ys [3];
	logic signed [act_pkg::ZW-1:0]      ang;
	logic signed [act_pkg::ZW-1:0]      zc [3];
	logic [24:0]                        rnd [3];
	logic [act_pkg::TILT_W-1:0]         tilt [3];

	logic [act_pkg::SUM_W:0]            sx [3];
	logic [act_pkg::SUM_W:0]            mag [3];
	logic [act_pkg::SUM_W:0]            dvd_q [3];
	logic [act_pkg::CNT_W-1:0]          rem_q [3];
	logic                               neg_q [3];
	logic [act_pkg::CNT_W:0]            dtry [3];
	logic                               qbit [3];
	logic signed [act_pkg::ACC_W-1:0]   quo [3];
	logic signed [act_pkg::ACC_W-1:0]   new_bias [3];

	assign raw_s[0] = act_pkg::sext_raw(raw_x);
	assign raw_s[1] = act_pkg::sext_raw(raw_y);
	assign raw_s[2] = act_pkg::sext_raw(raw_z);
	assign taken_nx = taken_q + 16'd1;
	assign ang      = act_pkg::ZW'(act_pkg::atan_tab(cmd.idx));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = 19'(raw_s[k]) - 19'(bias_q[k]);
			if (!bias_valid_q) begin
				corr[k] = raw_s[k];
			end else if (diff[k] > 19'sd65535) begin
				corr[k] = 17'sd65535;
			end else if (diff[k] < -19'sd65536) begin
				corr[k] = -17'sd65536;
			end else begin
				corr[k] = diff[k][act_pkg::ACC_W-1:0];
			end
			prod[k]  = 34'(acc_q[k]) * 34'(acc_q[k]);
			trial[k] = root_q[k] + bit_q;
			xa[k]    = {{(act_pkg::CW-act_pkg::ACC_W-15){acc_q[k][act_pkg::ACC_W-1]}},
				acc_q[k], 15'b0};
			yr[k]    = {{(act_pkg::CW-32){1'b0}}, root_q[k][31:0]};
			xs[k]    = cx_q[k] >>> cmd.idx;
			ys[k]    = cy_q[k] >>> cmd.idx;
			if (cz_q[k] < 0) begin
				zc[k] = '0;
			end else if (cz_q[k] > act_pkg::Z180) begin
				zc[k] = act_pkg::Z180;
			end else begin
				zc[k] = cz_q[k];
			end
			rnd[k]  = {1'b0, zc[k][23:0]} + 25'd128;
			tilt[k] = rnd[k][23:8];
			sx[k]   = {sum_q[k][act_pkg::SUM_W-1], sum_q[k]};
			mag[k]  = sum_q[k][act_pkg::SUM_W-1] ? -sx[k] : sx[k];
			dtry[k] = {rem_q[k], dvd_q[k][act_pkg::SUM_W]};
			qbit[k] = dtry[k] >= {1'b0, taken_q};
			quo[k]  = neg_q[k] ? -dvd_q[k][act_pkg::ACC_W-1:0] : dvd_q[k][act_pkg::ACC_W-1:0];
		end
		ss[0] = 34'(sq_q[1]) + 34'(sq_q[2]);
		ss[1] = 34'(sq_q[0]) + 34'(sq_q[2]);
		ss[2] = 34'(sq_q[0]) + 34'(sq_q[1]);
		new_bias[0] = quo[0];
		new_bias[1] = quo[1];
		new_bias[2] = quo[2] - act_pkg::ONE_G;
	end

	assign sts.zero_vec = (corr[0] == '0) && (corr[1] == '0) && (corr[2] == '0);
	assign sts.cal_last = taken_nx >= sample_count;
	assign sts.cnt_zero = sample_count == '0;

	// Calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_valid_q <= 1'b0;
			taken_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				bias_q[k] <= '0;
				sum_q[k]  <= '0;
			end
		end else if (cmd.clr) begin
			bias_valid_q <= 1'b0;
			taken_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				bias_q[k] <= '0;
				sum_q[k]  <= '0;
			end
		end else if (cmd.acc) begin
			taken_q <= taken_nx;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= sum_q[k] + 32'(raw_s[k]);
			end
		end else if (cmd.out_cal) begin
			bias_valid_q <= 1'b1;
			taken_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				bias_q[k] <= new_bias[k];
				sum_q[k]  <= '0;
			end
		end
	end

	// Working registers of the three lanes.
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sqrt_step) begin
			bit_q <= bit_q >> 2;
		end
		for (int k = 0; k < 3; k++) begin
			if (cmd.load_meas) begin
				acc_q[k] <= corr[k];
			end
			if (cmd.sq) begin
				sq_q[k] <= prod[k][2*act_pkg::ACC_W-2:0];
			end
			if (cmd.sum) begin
				rad_q[k]  <= {ss[k][33:0], 30'b0};
				root_q[k] <= '0;
			end else if (cmd.sqrt_step) begin
				if (rad_q[k] >= trial[k]) begin
					rad_q[k]  <= rad_q[k] - trial[k];
					root_q[k] <= (root_q[k] >> 1) + bit_q;
				end else begin
					root_q[k] <= root_q[k] >> 1;
				end
			end
			if (cmd.cord_init) begin
				if (xa[k] < 0) begin
					cx_q[k] <= yr[k];
					cy_q[k] <= -xa[k];
					cz_q[k] <= act_pkg::Z90;
				end else begin
					cx_q[k] <= xa[k];
					cy_q[k] <= yr[k];
					cz_q[k] <= '0;
				end
			end else if (cmd.cord_step) begin
				if (cy_q[k] > 0) begin
					cx_q[k] <= cx_q[k] + ys[k];
					cy_q[k] <= cy_q[k] - xs[k];
					cz_q[k] <= cz_q[k] + ang;
				end else begin
					cx_q[k] <= cx_q[k] - ys[k];
					cy_q[k] <= cy_q[k] + xs[k];
					cz_q[k] <= cz_q[k] - ang;
				end
			end
			if (cmd.div_init) begin
				neg_q[k] <= sum_q[k][act_pkg::SUM_W-1];
				dvd_q[k] <= mag[k] + {{(act_pkg::SUM_W+2-act_pkg::CNT_W){1'b0}},
					taken_q[act_pkg::CNT_W-1:1]};
				rem_q[k] <= '0;
			end else if (cmd.div_step) begin
				rem_q[k] <= qbit[k] ? 16'(dtry[k] - {1'b0, taken_q}) : dtry[k][15:0];
				dvd_q[k] <= {dvd_q[k][act_pkg::SUM_W-1:0], qbit[k]};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_meas) begin
			kind      <= act_pkg::KIND_TILT;
			acc_x     <= acc_q[0];
			acc_y     <= acc_q[1];
			acc_z     <= acc_q[2];
			tilt_x    <= tilt[0];
			tilt_y    <= tilt[1];
			tilt_z    <= tilt[2];
			cal_valid <= bias_valid_q;
		end else if (cmd.out_cal) begin
			kind      <= act_pkg::KIND_CAL;
			acc_x     <= new_bias[0];
			acc_y     <= new_bias[1];
			acc_z     <= new_bias[2];
			tilt_x    <= '0;
			tilt_y    <= '0;
			tilt_z    <= '0;
			cal_valid <= 1'b1;
		end
	end

endmodule

@@ src/act_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_ctrl: sequencer of the accelerometer tilt calibrator
// Accepts requests, steps the datapath through its iterations and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module act_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	output logic              out_valid,
	input  logic              out_ready,
	input  act_pkg::act_sts_t sts,
	output act_pkg::act_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQ    = 4'd1;
	localparam logic [3:0] S_SUM   = 4'd2;
	localparam logic [3:0] S_SQRT  = 4'd3;
	localparam logic [3:0] S_CINIT = 4'd4;
	localparam logic [3:0] S_CORD  = 4'd5;
	localparam logic [3:0] S_FINM  = 4'd6;
	localparam logic [3:0] S_DINIT = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_FINC  = 4'd9;

	logic [3:0]                   state_q;
	logic [3:0]                   state_nx;
	logic [act_pkg::STEP_W-1:0]   cnt_q;
	logic [act_pkg::STEP_W-1:0]   cnt_nx;
	logic                         out_free;
	logic                         wr_out;

	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid || out_ready;
	assign wr_out   = cmd.out_meas || cmd.out_cal;

	always_comb begin
		cmd      = '0;
		cmd.idx  = cnt_q[4:0];
		state_nx = state_q;
		cnt_nx   = cnt_q + 6'd1;
		case (state_q)
			S_IDLE: begin
				cnt_nx = '0;
				if (in_valid) begin
					case (mode)
						act_pkg::MODE_MEASURE: begin
							cmd.load_meas = 1'b1;
							if (!sts.zero_vec) begin
								state_nx = S_SQ;
							end
						end
						act_pkg::MODE_CAL: begin
							if (!sts.cnt_zero) begin
								cmd.acc = 1'b1;
								if (sts.cal_last) begin
									state_nx = S_DINIT;
								end
							end
						end
						act_pkg::MODE_CLEAR: begin
							cmd.clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_SQ: begin
				cmd.sq   = 1'b1;
				state_nx = S_SUM;
			end
			S_SUM: begin
				cmd.sum  = 1'b1;
				cnt_nx   = '0;
				state_nx = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == 6'(act_pkg::SQRT_STEPS - 1)) begin
					state_nx = S_CINIT;
				end
			end
			S_CINIT: begin
				cmd.cord_init = 1'b1;
				cnt_nx        = '0;
				state_nx      = S_CORD;
			end
			S_CORD: begin
				cmd.cord_step = 1'b1;
				if (cnt_q == 6'(act_pkg::CORDIC_STEPS - 1)) begin
					state_nx = S_FINM;
				end
			end
			S_FINM: begin
				if (out_free) begin
					cmd.out_meas = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_nx       = '0;
				state_nx     = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 6'(act_pkg::DIV_STEPS - 1)) begin
					state_nx = S_FINC;
				end
			end
			S_FINC: begin
				if (out_free) begin
					cmd.out_cal = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			if (wr_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
